// ===== rtl/core/bfpc_pkg.sv =====
// Shared types, codes and the command decoder of the Brainfuck program core.
package bfpc_pkg;

   // Field widths of the request and response transfers.
   localparam int OPERATION_WIDTH = 3;
   localparam int BYTE_WIDTH      = 8;
   localparam int STATUS_WIDTH    = 3;
   localparam int STEP_WIDTH      = 32;
   localparam int INSTR_WIDTH     = 3;

   // Number of entries in the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   // Operation codes carried by a request.
   localparam logic [OPERATION_WIDTH-1:0] OPERATION_LOAD          = 3'd0;
   localparam logic [OPERATION_WIDTH-1:0] OPERATION_FINISH        = 3'd1;
   localparam logic [OPERATION_WIDTH-1:0] OPERATION_STEP          = 3'd2;
   localparam logic [OPERATION_WIDTH-1:0] OPERATION_RESTART       = 3'd3;
   localparam logic [OPERATION_WIDTH-1:0] OPERATION_CLEAR_CELLS   = 3'd4;
   localparam logic [OPERATION_WIDTH-1:0] OPERATION_CLEAR_PROGRAM = 3'd5;

   // Status codes returned with every response.
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK         = 3'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_UNBALANCED = 3'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_RANGE      = 3'd2;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL       = 3'd3;
   localparam logic [STATUS_WIDTH-1:0] STATUS_HALTED     = 3'd4;

   // Stored instruction codes.
   localparam logic [INSTR_WIDTH-1:0] INSTR_RIGHT = 3'd0;
   localparam logic [INSTR_WIDTH-1:0] INSTR_LEFT  = 3'd1;
   localparam logic [INSTR_WIDTH-1:0] INSTR_INC   = 3'd2;
   localparam logic [INSTR_WIDTH-1:0] INSTR_DEC   = 3'd3;
   localparam logic [INSTR_WIDTH-1:0] INSTR_OUT   = 3'd4;
   localparam logic [INSTR_WIDTH-1:0] INSTR_IN    = 3'd5;
   localparam logic [INSTR_WIDTH-1:0] INSTR_OPEN  = 3'd6;
   localparam logic [INSTR_WIDTH-1:0] INSTR_CLOSE = 3'd7;

   // ASCII codes of the eight command characters.
   localparam logic [BYTE_WIDTH-1:0] CHAR_RIGHT = 8'h3E;
   localparam logic [BYTE_WIDTH-1:0] CHAR_LEFT  = 8'h3C;
   localparam logic [BYTE_WIDTH-1:0] CHAR_INC   = 8'h2B;
   localparam logic [BYTE_WIDTH-1:0] CHAR_DEC   = 8'h2D;
   localparam logic [BYTE_WIDTH-1:0] CHAR_OUT   = 8'h2E;
   localparam logic [BYTE_WIDTH-1:0] CHAR_IN    = 8'h2C;
   localparam logic [BYTE_WIDTH-1:0] CHAR_OPEN  = 8'h5B;
   localparam logic [BYTE_WIDTH-1:0] CHAR_CLOSE = 8'h5D;

   // Result of classifying one program character.
   typedef struct packed {
      logic                   is_command;
      logic [INSTR_WIDTH-1:0] opcode;
   } decode_type;

   // One classified request waiting in the queue.
   typedef struct packed {
      logic [OPERATION_WIDTH-1:0] operation;
      logic [BYTE_WIDTH-1:0]      data_byte;
      logic                       is_command;
      logic [INSTR_WIDTH-1:0]     opcode;
   } queue_entry_type;

   // Condition of the back end as seen by the rest of the core.
   typedef struct packed {
      logic clearing;
   } back_status_type;

   // Response payload held in the output register.
   typedef struct packed {
      logic [STATUS_WIDTH-1:0] status;
      logic                    out_valid;
      logic [BYTE_WIDTH-1:0]   out_byte;
      logic                    in_taken;
      logic [STEP_WIDTH-1:0]   step_count;
   } rsp_payload_type;

   // Maps a character to its instruction code; anything else is not a command.
   function automatic decode_type decode_char(input logic [BYTE_WIDTH-1:0] ch);
      decode_type d;
      d.is_command = 1'b1;
      d.opcode     = INSTR_RIGHT;
      case (ch)
         CHAR_RIGHT: d.opcode = INSTR_RIGHT;
         CHAR_LEFT:  d.opcode = INSTR_LEFT;
         CHAR_INC:   d.opcode = INSTR_INC;
         CHAR_DEC:   d.opcode = INSTR_DEC;
         CHAR_OUT:   d.opcode = INSTR_OUT;
         CHAR_IN:    d.opcode = INSTR_IN;
         CHAR_OPEN:  d.opcode = INSTR_OPEN;
         CHAR_CLOSE: d.opcode = INSTR_CLOSE;
         default:    d.is_command = 1'b0;
      endcase
      return d;
   endfunction

endpackage

// ===== rtl/core/bfpc_if.sv =====
// Request and response channel interfaces of the Brainfuck program core.
interface bfpc_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [bfpc_pkg::OPERATION_WIDTH-1:0] operation;
   logic [bfpc_pkg::BYTE_WIDTH-1:0]      data_byte;

   modport source (output valid, output operation, output data_byte, input ready);
   modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface bfpc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [bfpc_pkg::STATUS_WIDTH-1:0] status;
   logic                              out_valid;
   logic [bfpc_pkg::BYTE_WIDTH-1:0]   out_byte;
   logic                              in_taken;
   logic [bfpc_pkg::STEP_WIDTH-1:0]   step_count;

   modport source (output valid, output status, output out_valid, output out_byte,
                   output in_taken, output step_count, input ready);
   modport sink   (input valid, input status, input out_valid, input out_byte,
                   input in_taken, input step_count, output ready);
endinterface

// ===== rtl/core/bfpc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module bfpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write the addressed word and register the read word; a read of the word being written returns its old value.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== rtl/core/bfpc_fifo.sv =====
// Short queue of classified requests between the front and the back end.
module bfpc_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  bfpc_pkg::queue_entry_type push_entry,
   output logic                      full,
   input  logic                      pop,
   output logic                      valid,
   output bfpc_pkg::queue_entry_type head_entry
);

   localparam int DEPTH = bfpc_pkg::QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [PW:0]   COUNT_FULL = (PW + 1)'(DEPTH);

   bfpc_pkg::queue_entry_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;

   assign full       = (count_ff == COUNT_FULL);
   assign valid      = (count_ff != '0);
   assign head_entry = entry_ff[rd_ptr_ff];

   // Pointer and occupancy updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/core/bfpc_front.sv =====
// Front end: accepts requests and classifies program characters for the queue.
module bfpc_front (
   bfpc_req_if.sink                  req_chan,
   input  bfpc_pkg::back_status_type back_status,
   input  logic                      queue_full,
   output logic                      queue_push,
   output bfpc_pkg::queue_entry_type queue_entry
);

   bfpc_pkg::decode_type decoded;

   // A transfer is taken while the queue has room and no cell clearing pass runs.
   assign req_chan.ready = !queue_full && !back_status.clearing;
   assign queue_push     = req_chan.valid && req_chan.ready;

   // Classify the character so that the back end sees ready-made opcodes.
   assign decoded                = bfpc_pkg::decode_char(req_chan.data_byte);
   assign queue_entry.operation  = req_chan.operation;
   assign queue_entry.data_byte  = req_chan.data_byte;
   assign queue_entry.is_command = decoded.is_command;
   assign queue_entry.opcode     = decoded.opcode;

endmodule

// ===== rtl/core/bfpc_exec.sv =====
// Back end: program loading, bracket matching, instruction execution and responses.
module bfpc_exec #(
   parameter int CELL_COUNT = 4096,
   parameter int CODE_DEPTH = 4096,
   parameter int NEST_DEPTH = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      queue_valid,
   input  bfpc_pkg::queue_entry_type queue_entry,
   output logic                      queue_pop,
   output bfpc_pkg::back_status_type back_status,
   bfpc_rsp_if.source                rsp_chan
);

   localparam int CW = $clog2(CODE_DEPTH);
   localparam int DW = $clog2(CELL_COUNT);
   localparam int SW = $clog2(NEST_DEPTH);
   localparam int IW = bfpc_pkg::INSTR_WIDTH;
   localparam int BW = bfpc_pkg::BYTE_WIDTH;
   localparam int TW = bfpc_pkg::STEP_WIDTH;

   localparam logic [CW:0]   CODE_FULL = (CW + 1)'(CODE_DEPTH);
   localparam logic [SW:0]   NEST_FULL = (SW + 1)'(NEST_DEPTH);
   localparam logic [DW-1:0] DP_LAST   = DW'(CELL_COUNT - 1);

   typedef enum logic [4:0] {
      ST_SWEEP = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_EXEC  = 5'b00100,
      ST_POP   = 5'b01000,
      ST_MATCH = 5'b10000
   } state_type;

   state_type     state_ff, state_in;
   logic [DW-1:0] sweep_ff, sweep_in;
   logic [CW:0]   code_len_ff, code_len_in;
   logic [CW:0]   instr_ptr_ff, instr_ptr_in;
   logic [DW-1:0] data_ptr_ff, data_ptr_in;
   logic [SW:0]   depth_ff, depth_in;
   logic          bad_ff, bad_in;
   logic [TW-1:0] executed_ff, executed_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [CW-1:0] partner_ff, partner_in;
   logic [BW-1:0] byte_ff, byte_in;
   logic          rsp_valid_ff;
   bfpc_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic          done;
   logic          slot_free;
   logic [SW:0]   depth_dec;

   logic          code_we;
   logic [IW-1:0] code_rdata;
   logic          match_we;
   logic [CW-1:0] match_waddr, match_wdata, match_rdata;
   logic          stack_we;
   logic [CW-1:0] stack_rdata;
   logic          cell_we;
   logic [DW-1:0] cell_waddr;
   logic [BW-1:0] cell_wdata, cell_rdata;

   // Program, bracket partners, open brackets and data cells.
   bfpc_ram #(.WIDTH(IW), .DEPTH(CODE_DEPTH)) u_code_ram (
      .clock (clock),
      .we    (code_we),
      .waddr (code_len_ff[CW-1:0]),
      .wdata (queue_entry.opcode),
      .raddr (instr_ptr_ff[CW-1:0]),
      .rdata (code_rdata)
   );

   bfpc_ram #(.WIDTH(CW), .DEPTH(CODE_DEPTH)) u_match_ram (
      .clock (clock),
      .we    (match_we),
      .waddr (match_waddr),
      .wdata (match_wdata),
      .raddr (instr_ptr_ff[CW-1:0]),
      .rdata (match_rdata)
   );

   bfpc_ram #(.WIDTH(CW), .DEPTH(NEST_DEPTH)) u_stack_ram (
      .clock (clock),
      .we    (stack_we),
      .waddr (depth_ff[SW-1:0]),
      .wdata (code_len_ff[CW-1:0]),
      .raddr (depth_dec[SW-1:0]),
      .rdata (stack_rdata)
   );

   bfpc_ram #(.WIDTH(BW), .DEPTH(CELL_COUNT)) u_cell_ram (
      .clock (clock),
      .we    (cell_we),
      .waddr (cell_waddr),
      .wdata (cell_wdata),
      .raddr (data_ptr_ff),
      .rdata (cell_rdata)
   );

   assign depth_dec = depth_ff - (SW + 1)'(1);

   // Once the output register is free it stays free until this unit fills it.
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   assign back_status.clearing = (state_ff == ST_SWEEP);

   // Sequencer for every operation.
   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      code_len_in  = code_len_ff;
      instr_ptr_in = instr_ptr_ff;
      data_ptr_in  = data_ptr_ff;
      depth_in     = depth_ff;
      bad_in       = bad_ff;
      executed_in  = executed_ff;
      pos_in       = pos_ff;
      partner_in   = partner_ff;
      byte_in      = byte_ff;
      queue_pop    = 1'b0;
      done         = 1'b0;
      code_we      = 1'b0;
      match_we     = 1'b0;
      match_waddr  = pos_ff;
      match_wdata  = partner_ff;
      stack_we     = 1'b0;
      cell_we      = 1'b0;
      cell_waddr   = data_ptr_ff;
      cell_wdata   = '0;
      rsp_in       = '0;
      rsp_in.status = bfpc_pkg::STATUS_OK;

      case (state_ff)
         ST_SWEEP: begin
            // Clear one cell per cycle.
            cell_we    = 1'b1;
            cell_waddr = sweep_ff;
            if (sweep_ff == DP_LAST) begin
               state_in = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (queue_valid && slot_free) begin
               queue_pop = 1'b1;
               byte_in   = queue_entry.data_byte;
               case (queue_entry.operation)
                  bfpc_pkg::OPERATION_LOAD: begin
                     if (!queue_entry.is_command) begin
                        done = 1'b1;
                     end else if (code_len_ff == CODE_FULL) begin
                        done          = 1'b1;
                        rsp_in.status = bfpc_pkg::STATUS_FULL;
                     end else begin
                        // The command is stored even when its bracket is rejected.
                        code_we     = 1'b1;
                        code_len_in = code_len_ff + 1'b1;
                        pos_in      = code_len_ff[CW-1:0];
                        if (queue_entry.opcode == bfpc_pkg::INSTR_OPEN) begin
                           done = 1'b1;
                           if (depth_ff == NEST_FULL) begin
                              bad_in        = 1'b1;
                              rsp_in.status = bfpc_pkg::STATUS_UNBALANCED;
                           end else begin
                              stack_we = 1'b1;
                              depth_in = depth_ff + 1'b1;
                           end
                        end else if (queue_entry.opcode == bfpc_pkg::INSTR_CLOSE) begin
                           if (depth_ff == '0) begin
                              done          = 1'b1;
                              bad_in        = 1'b1;
                              rsp_in.status = bfpc_pkg::STATUS_UNBALANCED;
                           end else begin
                              // The stack top is read now and paired next cycle.
                              depth_in = depth_dec;
                              state_in = ST_POP;
                           end
                        end else begin
                           done = 1'b1;
                        end
                     end
                  end

                  bfpc_pkg::OPERATION_FINISH: begin
                     done = 1'b1;
                     if (bad_ff || depth_ff != '0) begin
                        bad_in        = 1'b1;
                        rsp_in.status = bfpc_pkg::STATUS_UNBALANCED;
                     end
                  end

                  bfpc_pkg::OPERATION_STEP: begin
                     if (bad_ff || depth_ff != '0) begin
                        done          = 1'b1;
                        rsp_in.status = bfpc_pkg::STATUS_UNBALANCED;
                     end else if (instr_ptr_ff >= code_len_ff) begin
                        done          = 1'b1;
                        rsp_in.status = bfpc_pkg::STATUS_HALTED;
                     end else begin
                        // Instruction, partner and cell are read this cycle.
                        state_in = ST_EXEC;
                     end
                  end

                  bfpc_pkg::OPERATION_RESTART: begin
                     done         = 1'b1;
                     instr_ptr_in = '0;
                     executed_in  = '0;
                  end

                  bfpc_pkg::OPERATION_CLEAR_CELLS: begin
                     done        = 1'b1;
                     data_ptr_in = '0;
                     sweep_in    = '0;
                     state_in    = ST_SWEEP;
                  end

                  bfpc_pkg::OPERATION_CLEAR_PROGRAM: begin
                     done         = 1'b1;
                     code_len_in  = '0;
                     instr_ptr_in = '0;
                     depth_in     = '0;
                     bad_in       = 1'b0;
                  end

                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end

         ST_EXEC: begin
            // Execute the instruction read in the previous cycle.
            done         = 1'b1;
            state_in     = ST_IDLE;
            instr_ptr_in = instr_ptr_ff + 1'b1;
            executed_in  = executed_ff + 1'b1;
            case (code_rdata)
               bfpc_pkg::INSTR_RIGHT: begin
                  if (data_ptr_ff == DP_LAST) begin
                     rsp_in.status = bfpc_pkg::STATUS_RANGE;
                     instr_ptr_in  = instr_ptr_ff;
                     executed_in   = executed_ff;
                  end else begin
                     data_ptr_in = data_ptr_ff + 1'b1;
                  end
               end
               bfpc_pkg::INSTR_LEFT: begin
                  if (data_ptr_ff == '0) begin
                     rsp_in.status = bfpc_pkg::STATUS_RANGE;
                     instr_ptr_in  = instr_ptr_ff;
                     executed_in   = executed_ff;
                  end else begin
                     data_ptr_in = data_ptr_ff - 1'b1;
                  end
               end
               bfpc_pkg::INSTR_INC: begin
                  cell_we    = 1'b1;
                  cell_wdata = cell_rdata + 1'b1;
               end
               bfpc_pkg::INSTR_DEC: begin
                  cell_we    = 1'b1;
                  cell_wdata = cell_rdata - 1'b1;
               end
               bfpc_pkg::INSTR_OUT: begin
                  rsp_in.out_valid = 1'b1;
                  rsp_in.out_byte  = cell_rdata;
               end
               bfpc_pkg::INSTR_IN: begin
                  cell_we         = 1'b1;
                  cell_wdata      = byte_ff;
                  rsp_in.in_taken = 1'b1;
               end
               bfpc_pkg::INSTR_OPEN: begin
                  if (cell_rdata == '0) begin
                     instr_ptr_in = {1'b0, match_rdata} + 1'b1;
                  end
               end
               bfpc_pkg::INSTR_CLOSE: begin
                  if (cell_rdata != '0) begin
                     instr_ptr_in = {1'b0, match_rdata} + 1'b1;
                  end
               end
               default: begin
                  instr_ptr_in = instr_ptr_ff;
                  executed_in  = executed_ff;
               end
            endcase
         end

         ST_POP: begin
            // The closing bracket points back at its partner.
            match_we    = 1'b1;
            match_waddr = pos_ff;
            match_wdata = stack_rdata;
            partner_in  = stack_rdata;
            state_in    = ST_MATCH;
         end

         ST_MATCH: begin
            // The opening bracket points forward at its partner.
            match_we    = 1'b1;
            match_waddr = partner_ff;
            match_wdata = pos_ff;
            done        = 1'b1;
            state_in    = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_in.step_count = executed_in;
   end

   // Control state; reset starts with a full cell clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         code_len_ff  <= '0;
         instr_ptr_ff <= '0;
         data_ptr_ff  <= '0;
         depth_ff     <= '0;
         bad_ff       <= 1'b0;
         executed_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         code_len_ff  <= code_len_in;
         instr_ptr_ff <= instr_ptr_in;
         data_ptr_ff  <= data_ptr_in;
         depth_ff     <= depth_in;
         bad_ff       <= bad_in;
         executed_ff  <= executed_in;
         if (done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      partner_ff <= partner_in;
      byte_ff    <= byte_in;
      if (done) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_ff.status;
   assign rsp_chan.out_valid  = rsp_ff.out_valid;
   assign rsp_chan.out_byte   = rsp_ff.out_byte;
   assign rsp_chan.in_taken   = rsp_ff.in_taken;
   assign rsp_chan.step_count = rsp_ff.step_count;

endmodule

// ===== rtl/core/brainfuck_program_core_top.sv =====
// Top level of the Brainfuck program core: front end, request queue and back end.
//
// Each request transfer gives exactly one response transfer, in order. A front end classifies
// program characters and places requests in a two-entry queue; the back end carries them out
// one at a time behind a response register, so the queue still takes requests while a response
// waits, until it is full. In the back end a load, finish, restart, clear-program or unknown
// operation is answered from the idle state; a step reads the code, match and cell RAMs, then
// executes, writing the cell if the instruction does; a ']' that closes an open bracket reads
// the bracket stack RAM, then writes both match table entries in turn through its single write
// port. Clear-cells answers at once and then sweeps the cell RAM one cell per cycle; after reset
// the same sweep runs. During a sweep req_chan.ready stays low. Program and match storage hold
// whatever was last written; a step is refused unless the program is balanced.
module brainfuck_program_core_top #(
   parameter int CELL_COUNT = 4096,
   parameter int CODE_DEPTH = 4096,
   parameter int NEST_DEPTH = 64
) (
   input logic        clock,
   input logic        reset,
   bfpc_req_if.sink   req_chan,
   bfpc_rsp_if.source rsp_chan
);

   bfpc_pkg::back_status_type back_status;
   bfpc_pkg::queue_entry_type push_entry;
   bfpc_pkg::queue_entry_type head_entry;
   logic queue_push;
   logic queue_full;
   logic queue_pop;
   logic queue_valid;

   // Request acceptance and classification.
   bfpc_front u_front (
      .req_chan    (req_chan),
      .back_status (back_status),
      .queue_full  (queue_full),
      .queue_push  (queue_push),
      .queue_entry (push_entry)
   );

   // Decoupling queue.
   bfpc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (queue_pop),
      .valid      (queue_valid),
      .head_entry (head_entry)
   );

   // Execution and responses.
   bfpc_exec #(
      .CELL_COUNT (CELL_COUNT),
      .CODE_DEPTH (CODE_DEPTH),
      .NEST_DEPTH (NEST_DEPTH)
   ) u_exec (
      .clock       (clock),
      .reset       (reset),
      .queue_valid (queue_valid),
      .queue_entry (head_entry),
      .queue_pop   (queue_pop),
      .back_status (back_status),
      .rsp_chan    (rsp_chan)
   );

   // No request is taken while the cells are being cleared.
   assert property (@(posedge clock) disable iff (reset)
      back_status.clearing |-> !req_chan.ready)
      else $error("request taken during cell clearing pass");

   // A request leaves the queue only when its response has somewhere to go.
   assert property (@(posedge clock) disable iff (reset)
      queue_pop |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("request dequeued while response register is occupied");

   // The front never pushes into a full queue.
   assert property (@(posedge clock) disable iff (reset)
      queue_push |-> !queue_full)
      else $error("push into full request queue");

endmodule

// ===== dv/brainfuck_program_core_top_tb.sv =====
// Self-checking testbench of the Brainfuck program core, with its own predictor and scoreboard.
module brainfuck_program_core_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CELL_COUNT   = 4096;
   localparam int CODE_DEPTH   = 4096;
   localparam int NEST_DEPTH   = 64;
   localparam int RANDOM_ITEMS = 1330;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 20;
   // Worst quiet stretch: a full cell sweep plus the long receiver hold and a long gap.
   localparam int QUIET_LIMIT  = 5 * (CELL_COUNT + HOLD_CYCLES + 64);

   // Operation codes that the core has no use for.
   localparam logic [bfpc_pkg::OPERATION_WIDTH-1:0] OPERATION_SPARE_A = 3'd6;
   localparam logic [bfpc_pkg::OPERATION_WIDTH-1:0] OPERATION_SPARE_B = 3'd7;

   // One request waiting to be offered; idle_first holds it back until every response is in.
   typedef struct packed {
      logic [bfpc_pkg::OPERATION_WIDTH-1:0] operation;
      logic [bfpc_pkg::BYTE_WIDTH-1:0]      data_byte;
      logic                                 idle_first;
   } bf_request_type;

   logic clock;
   logic reset;

   bfpc_req_if req_chan ();
   bfpc_rsp_if rsp_chan ();

   brainfuck_program_core_top #(
      .CELL_COUNT(CELL_COUNT),
      .CODE_DEPTH(CODE_DEPTH),
      .NEST_DEPTH(NEST_DEPTH)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   bf_request_type            backlog[$];
   bfpc_pkg::rsp_payload_type awaited_rsp[$];

   int send_gap      = 0;
   int sent_count    = 0;
   int rsp_stall     = 0;
   int rsp_hold      = 0;
   int rsp_taken     = 0;
   int fail_count    = 0;
   int quiet_cycles  = 0;
   int queued_total  = 0;

   // Predicted machine state.
   logic [bfpc_pkg::BYTE_WIDTH-1:0]  bf_cells   [CELL_COUNT];
   logic [bfpc_pkg::INSTR_WIDTH-1:0] bf_code    [CODE_DEPTH];
   int unsigned                      bf_partner [CODE_DEPTH];
   int unsigned                      bf_open    [NEST_DEPTH];
   int unsigned                      bf_nest   = 0;
   int unsigned                      bf_len    = 0;
   int unsigned                      bf_ip     = 0;
   int unsigned                      bf_dp     = 0;
   logic [bfpc_pkg::STEP_WIDTH-1:0]  bf_steps  = '0;
   bit                               bf_broken = 1'b0;

   initial begin
      foreach (bf_cells[i]) bf_cells[i] = '0;
   end

   always #6 clock = ~clock;

   // Gap length: mostly none or short, now and then long; none at all in calm stretches.
   function automatic int pick_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic add_req(input logic [bfpc_pkg::OPERATION_WIDTH-1:0] op,
                          input logic [bfpc_pkg::BYTE_WIDTH-1:0] data,
                          input bit idle_first = 1'b0);
      backlog.insert(backlog.size(), '{operation: op, data_byte: data, idle_first: idle_first});
      queued_total++;
   endtask

   // A character that is not a command, so the load leaves the program alone.
   task automatic add_noise_char();
      add_req(bfpc_pkg::OPERATION_LOAD, $urandom_range(0, 1) ? 8'($urandom_range(8'h61, 8'h7A))
                                                             : 8'($urandom_range(8'h80, 8'hFF)));
   endtask

   // Applies one request to the predicted state and works out its response.
   task automatic apply_request(input logic [bfpc_pkg::OPERATION_WIDTH-1:0] op,
                                input logic [bfpc_pkg::BYTE_WIDTH-1:0] data_in,
                                output bfpc_pkg::rsp_payload_type want);
      logic [bfpc_pkg::INSTR_WIDTH-1:0] opc;
      logic [bfpc_pkg::BYTE_WIDTH-1:0]  cell_val;
      bit                               is_cmd;
      int unsigned                      pos;
      int unsigned                      next_ip;
      want = '0;
      case (op)
         bfpc_pkg::OPERATION_LOAD: begin
            is_cmd = 1'b1;
            opc    = bfpc_pkg::INSTR_RIGHT;
            case (data_in)
               bfpc_pkg::CHAR_RIGHT: opc = bfpc_pkg::INSTR_RIGHT;
               bfpc_pkg::CHAR_LEFT:  opc = bfpc_pkg::INSTR_LEFT;
               bfpc_pkg::CHAR_INC:   opc = bfpc_pkg::INSTR_INC;
               bfpc_pkg::CHAR_DEC:   opc = bfpc_pkg::INSTR_DEC;
               bfpc_pkg::CHAR_OUT:   opc = bfpc_pkg::INSTR_OUT;
               bfpc_pkg::CHAR_IN:    opc = bfpc_pkg::INSTR_IN;
               bfpc_pkg::CHAR_OPEN:  opc = bfpc_pkg::INSTR_OPEN;
               bfpc_pkg::CHAR_CLOSE: opc = bfpc_pkg::INSTR_CLOSE;
               default:              is_cmd = 1'b0;
            endcase
            if (is_cmd && bf_len >= CODE_DEPTH) begin
               want.status = bfpc_pkg::STATUS_FULL;
            end else if (is_cmd) begin
               pos = bf_len;
               bf_code[pos] = opc;
               bf_len++;
               // Brackets are paired as they arrive; a stray or too deep one spoils the program.
               if (opc == bfpc_pkg::INSTR_OPEN) begin
                  if (bf_nest >= NEST_DEPTH) begin
                     bf_broken   = 1'b1;
                     want.status = bfpc_pkg::STATUS_UNBALANCED;
                  end else begin
                     bf_open[bf_nest] = pos;
                     bf_nest++;
                  end
               end else if (opc == bfpc_pkg::INSTR_CLOSE) begin
                  if (bf_nest == 0) begin
                     bf_broken   = 1'b1;
                     want.status = bfpc_pkg::STATUS_UNBALANCED;
                  end else begin
                     bf_nest--;
                     bf_partner[pos]              = bf_open[bf_nest];
                     bf_partner[bf_open[bf_nest]] = pos;
                  end
               end
            end
         end
         bfpc_pkg::OPERATION_FINISH: begin
            if (bf_broken || bf_nest != 0) begin
               bf_broken   = 1'b1;
               want.status = bfpc_pkg::STATUS_UNBALANCED;
            end
         end
         bfpc_pkg::OPERATION_STEP: begin
            next_ip = bf_ip;
            if (bf_broken || bf_nest != 0) begin
               want.status = bfpc_pkg::STATUS_UNBALANCED;
            end else if (bf_ip >= bf_len) begin
               want.status = bfpc_pkg::STATUS_HALTED;
            end else if ((bf_code[bf_ip] == bfpc_pkg::INSTR_RIGHT && bf_dp == CELL_COUNT - 1) ||
                         (bf_code[bf_ip] == bfpc_pkg::INSTR_LEFT && bf_dp == 0)) begin
               // A move off either end of the tape changes nothing.
               want.status = bfpc_pkg::STATUS_RANGE;
            end else begin
               cell_val = bf_cells[bf_dp];
               case (bf_code[bf_ip])
                  bfpc_pkg::INSTR_RIGHT: bf_dp++;
                  bfpc_pkg::INSTR_LEFT:  bf_dp--;
                  bfpc_pkg::INSTR_INC:   bf_cells[bf_dp] = cell_val + 8'd1;
                  bfpc_pkg::INSTR_DEC:   bf_cells[bf_dp] = cell_val - 8'd1;
                  bfpc_pkg::INSTR_OUT: begin
                     want.out_valid = 1'b1;
                     want.out_byte  = cell_val;
                  end
                  bfpc_pkg::INSTR_IN: begin
                     bf_cells[bf_dp] = data_in;
                     want.in_taken   = 1'b1;
                  end
                  bfpc_pkg::INSTR_OPEN:  if (cell_val == 0) next_ip = bf_partner[bf_ip];
                  default:               if (cell_val != 0) next_ip = bf_partner[bf_ip];
               endcase
               bf_ip = next_ip + 1;
               bf_steps++;
            end
         end
         bfpc_pkg::OPERATION_RESTART: begin
            bf_ip    = 0;
            bf_steps = '0;
         end
         bfpc_pkg::OPERATION_CLEAR_CELLS: begin
            foreach (bf_cells[i]) bf_cells[i] = '0;
            bf_dp = 0;
         end
         bfpc_pkg::OPERATION_CLEAR_PROGRAM: begin
            bf_len    = 0;
            bf_ip     = 0;
            bf_nest   = 0;
            bf_broken = 1'b0;
         end
         default: ;
      endcase
      want.step_count = bf_steps;
   endtask

   // Request driver: offers queued requests with random gaps between transfers.
   always @(posedge clock) begin : request_driver
      bf_request_type next_req;
      bit             sent_now;
      sent_now = req_chan.valid && req_chan.ready;
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (sent_now) begin
            sent_count++;
            send_gap = pick_gap(((sent_count / 128) % 4) == 1);
         end
         if (req_chan.valid && !req_chan.ready) begin
            // Hold the offered request until it is taken.
         end else if (send_gap > 0) begin
            send_gap--;
            req_chan.valid <= 1'b0;
         end else if (backlog.size() != 0 &&
                      !(backlog[0].idle_first && (sent_now || awaited_rsp.size() != 0))) begin
            next_req = backlog.pop_front();
            req_chan.valid     <= 1'b1;
            req_chan.operation <= next_req.operation;
            req_chan.data_byte <= next_req.data_byte;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Response receiver: random stalls, and two long holds while requests keep coming.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall = 0;
         rsp_hold  = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_taken++;
            rsp_stall = pick_gap(((rsp_taken / 128) % 4) == 3);
            if (rsp_taken == 200 || rsp_taken == 1000) rsp_hold = HOLD_CYCLES;
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_chan.ready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Scoreboard: predicts on each request transfer and checks each response transfer.
   always @(posedge clock) begin : scoreboard
      bfpc_pkg::rsp_payload_type want;
      bfpc_pkg::rsp_payload_type got;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            apply_request(req_chan.operation, req_chan.data_byte, want);
            awaited_rsp.insert(awaited_rsp.size(), want);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{status: rsp_chan.status, out_valid: rsp_chan.out_valid,
                    out_byte: rsp_chan.out_byte, in_taken: rsp_chan.in_taken,
                    step_count: rsp_chan.step_count};
            if (awaited_rsp.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("Unexpected response at %0t: status %0d out %0b/%02h in %0b steps %0d",
                           $realtime, got.status, got.out_valid, got.out_byte, got.in_taken,
                           got.step_count);
            end else begin
               want = awaited_rsp.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("Mismatch at %0t: expected status %0d out %0b/%02h in %0b steps %0d",
                              $realtime, want.status, want.out_valid, want.out_byte,
                              want.in_taken, want.step_count);
                     $display("   got status %0d out %0b/%02h in %0b steps %0d",
                              got.status, got.out_valid, got.out_byte, got.in_taken,
                              got.step_count);
                  end
               end
            end
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL brainfuck_program_core_top");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus: directed checks, the nesting limit, then random programs.
   initial begin : stimulus
      logic [bfpc_pkg::BYTE_WIDTH-1:0]      commands [8];
      logic [bfpc_pkg::OPERATION_WIDTH-1:0] stray_ops [7];
      logic [bfpc_pkg::OPERATION_WIDTH-1:0] op;
      int r;
      int w;
      int len;
      int depth;
      int idx;
      int random_base;
      commands  = '{bfpc_pkg::CHAR_RIGHT, bfpc_pkg::CHAR_LEFT, bfpc_pkg::CHAR_INC,
                    bfpc_pkg::CHAR_DEC, bfpc_pkg::CHAR_OUT, bfpc_pkg::CHAR_IN,
                    bfpc_pkg::CHAR_OPEN, bfpc_pkg::CHAR_CLOSE};
      stray_ops = '{bfpc_pkg::OPERATION_LOAD, bfpc_pkg::OPERATION_FINISH,
                    bfpc_pkg::OPERATION_STEP, bfpc_pkg::OPERATION_RESTART,
                    bfpc_pkg::OPERATION_CLEAR_PROGRAM, OPERATION_SPARE_A, OPERATION_SPARE_B};
      clock              = 1'b0;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.operation = bfpc_pkg::OPERATION_LOAD;
      req_chan.data_byte = '0;
      rsp_chan.ready     = 1'b0;

      // Empty program: a step halts, finishing is fine, junk and spare codes do nothing.
      add_req(bfpc_pkg::OPERATION_STEP, 8'h00);
      add_req(bfpc_pkg::OPERATION_FINISH, 8'hFF);
      add_req(bfpc_pkg::OPERATION_LOAD, 8'h00);
      add_req(OPERATION_SPARE_A, 8'hFF);
      add_req(OPERATION_SPARE_B, 8'h00);
      // Input, output, wrap to zero, skipped loop, then a move off the left end, twice.
      add_req(bfpc_pkg::OPERATION_LOAD, bfpc_pkg::CHAR_IN);
      add_req(bfpc_pkg::OPERATION_LOAD, bfpc_pkg::CHAR_OUT);
      add_req(bfpc_pkg::OPERATION_LOAD, bfpc_pkg::CHAR_INC);
      add_req(bfpc_pkg::OPERATION_LOAD, bfpc_pkg::CHAR_OPEN);
      add_req(bfpc_pkg::OPERATION_LOAD, bfpc_pkg::CHAR_DEC);
      add_req(bfpc_pkg::OPERATION_LOAD, bfpc_pkg::CHAR_CLOSE);
      add_req(bfpc_pkg::OPERATION_LOAD, bfpc_pkg::CHAR_LEFT);
      add_req(bfpc_pkg::OPERATION_FINISH, 8'h00);
      add_req(bfpc_pkg::OPERATION_STEP, 8'hFF);
      repeat (5) add_req(bfpc_pkg::OPERATION_STEP, 8'h00);
      add_req(bfpc_pkg::OPERATION_RESTART, 8'hFF);
      add_req(bfpc_pkg::OPERATION_CLEAR_CELLS, 8'h00);
      // A stray close bracket spoils the program until it is cleared.
      add_req(bfpc_pkg::OPERATION_LOAD, bfpc_pkg::CHAR_CLOSE);
      add_req(bfpc_pkg::OPERATION_STEP, 8'h00);
      add_req(bfpc_pkg::OPERATION_FINISH, 8'h00);
      add_req(bfpc_pkg::OPERATION_CLEAR_PROGRAM, 8'hFF);
      add_req(bfpc_pkg::OPERATION_LOAD, bfpc_pkg::CHAR_OPEN);
      add_req(bfpc_pkg::OPERATION_FINISH, 8'h00);

      // Nesting one level too deep, offered only once everything before has answered.
      add_req(bfpc_pkg::OPERATION_CLEAR_PROGRAM, 8'h00, 1'b1);
      repeat (NEST_DEPTH + 1) add_req(bfpc_pkg::OPERATION_LOAD, bfpc_pkg::CHAR_OPEN);
      add_req(bfpc_pkg::OPERATION_FINISH, 8'h00);
      add_req(bfpc_pkg::OPERATION_STEP, 8'h00);

      // Random part: mostly well-formed programs that are run, some broken loads, stray operations and cell clears.
      random_base = queued_total;
      while (queued_total - random_base < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            add_req(bfpc_pkg::OPERATION_CLEAR_PROGRAM, 8'($urandom_range(0, 255)),
                    $urandom_range(0, 9) == 0);
            len   = $urandom_range(1, 24);
            depth = 0;
            for (int i = 0; i < len; i++) begin
               w = $urandom_range(0, 99);
               if (depth > 0 && w < 15) begin
                  add_req(bfpc_pkg::OPERATION_LOAD, bfpc_pkg::CHAR_CLOSE);
                  depth--;
               end else if (depth < 4 && w < 30) begin
                  add_req(bfpc_pkg::OPERATION_LOAD, bfpc_pkg::CHAR_OPEN);
                  depth++;
               end else if (w < 36) begin
                  add_noise_char();
               end else begin
                  w   = $urandom_range(0, 99);
                  idx = (w < 20) ? 0 : (w < 30) ? 1 : (w < 55) ? 2 : (w < 70) ? 3 :
                        (w < 85) ? 4 : 5;
                  add_req(bfpc_pkg::OPERATION_LOAD, commands[idx]);
               end
            end
            repeat (depth) add_req(bfpc_pkg::OPERATION_LOAD, bfpc_pkg::CHAR_CLOSE);
            if ($urandom_range(0, 3) != 0)
               add_req(bfpc_pkg::OPERATION_FINISH, 8'($urandom_range(0, 255)));
            add_req(bfpc_pkg::OPERATION_RESTART, 8'($urandom_range(0, 255)));
            repeat ($urandom_range(4, 40)) begin
               if ($urandom_range(0, 49) == 0)
                  add_req(bfpc_pkg::OPERATION_RESTART, 8'($urandom_range(0, 255)));
               else
                  add_req(bfpc_pkg::OPERATION_STEP, 8'($urandom_range(0, 255)));
            end
         end else if (r < 85) begin
            // Broken load: unpaired brackets and arbitrary bytes, then a few steps.
            add_req(bfpc_pkg::OPERATION_CLEAR_PROGRAM, 8'($urandom_range(0, 255)));
            repeat ($urandom_range(1, 12)) begin
               w = $urandom_range(0, 99);
               if (w < 50)
                  add_req(bfpc_pkg::OPERATION_LOAD, commands[$urandom_range(0, 7)]);
               else if (w < 70)
                  add_noise_char();
               else
                  add_req(bfpc_pkg::OPERATION_LOAD, 8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 1))
               add_req(bfpc_pkg::OPERATION_FINISH, 8'($urandom_range(0, 255)));
            repeat ($urandom_range(1, 4))
               add_req(bfpc_pkg::OPERATION_STEP, 8'($urandom_range(0, 255)));
         end else if (r < 95) begin
            repeat ($urandom_range(1, 4)) begin
               op = stray_ops[$urandom_range(0, 6)];
               add_req(op, 8'($urandom_range(0, 255)));
            end
         end else begin
            add_req(bfpc_pkg::OPERATION_CLEAR_CELLS, 8'($urandom_range(0, 255)));
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Wait for every request to be taken and answered, then let the core settle.
      while (backlog.size() != 0 || req_chan.valid || awaited_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && awaited_rsp.size() == 0)
         $display("PASS brainfuck_program_core_top");
      else
         $display("FAIL brainfuck_program_core_top");
      $finish;
   end

endmodule

// ===== brainfuck_program_core_top.f =====
rtl/core/bfpc_pkg.sv
rtl/core/bfpc_if.sv
rtl/core/bfpc_ram.sv
rtl/core/bfpc_fifo.sv
rtl/core/bfpc_front.sv
rtl/core/bfpc_exec.sv
rtl/core/brainfuck_program_core_top.sv
dv/brainfuck_program_core_top_tb.sv
